// ----- rtl/core/kpb_pkg.sv -----
// Shared types, constants and helper functions for the k-mer presence unit.
// Used by every module under rtl/core; depends on nothing.
package kpb_pkg;

    // K-mer length and the window it needs at two bits per base.
    localparam int KMER_LEN = 8;
    localparam int WIN_W    = 2 * KMER_LEN;
    localparam int RUN_W    = $clog2(KMER_LEN + 1);

    // Field widths of the words on both channels.
    localparam int CHAR_W = 8;
    localparam int ID_W   = 20;
    localparam int CODE_W = 16;
    localparam int CNT_W  = 17;

    // The presence map covers the whole 16-bit code space as rows of 64 bits.
    localparam int MAP_BIT_W  = 6;
    localparam int MAP_BITS   = 1 << MAP_BIT_W;
    localparam int MAP_IDX_W  = CODE_W - MAP_BIT_W;
    localparam int MAP_ROWS   = 1 << MAP_IDX_W;
    localparam int EPOCH_W    = 12;

    // Saturation limit of the distinct count.
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1 << CODE_W);

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_N_UP = 8'h4E;
    localparam logic [CHAR_W-1:0] CH_N_LO = 8'h6E;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CH_T_LO = 8'h74;

    // Base codes.
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // Result kinds.
    localparam logic RK_REPORT  = 1'b0;
    localparam logic RK_SUMMARY = 1'b1;

    // Configuration register indexes.
    localparam logic REG_REPORT = 1'b0;

    // Input word.
    typedef struct packed {
        logic [CHAR_W-1:0] base_char;
        logic              monomer_start;
        logic              monomer_end;
        logic [ID_W-1:0]   seq_id;
    } t_in_item;

    // Result word.
    typedef struct packed {
        logic              result_kind;
        logic [CODE_W-1:0] kmer_code;
        logic [ID_W-1:0]   owner_id;
        logic [CNT_W-1:0]  distinct_kmers;
        logic              run_last;
    } t_out_item;

    // Classified job passed from the front to the back.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              lookup;
        logic              mono_start;
        logic              mono_end;
        logic [ID_W-1:0]   id;
    } t_job;

    // One row of the presence map with the epoch it was written in.
    typedef struct packed {
        logic [EPOCH_W-1:0]  tag;
        logic [MAP_BITS-1:0] bits;
    } t_map_row;

    // Up to two results handed together from the back to the result queue.
    typedef struct packed {
        logic      push0;
        logic      push1;
        t_out_item res0;
        t_out_item res1;
    } t_res_push;

    // Maps a character to its 2-bit code; unknown characters count as A.
    function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [1:0] code;
        begin
            case (ch)
                CH_C_UP, CH_C_LO: code = BASE_C;
                CH_G_UP, CH_G_LO: code = BASE_G;
                CH_T_UP, CH_T_LO: code = BASE_T;
                default:          code = BASE_A;
            endcase
            return code;
        end
    endfunction

    // True for the characters that break a k-mer.
    function automatic logic is_break(input logic [CHAR_W-1:0] ch);
        return (ch == CH_N_UP) || (ch == CH_N_LO);
    endfunction

endpackage

// ----- rtl/core/kpb_front.sv -----
// Front part: keeps the base window and clean run and classifies each word.
// Depends on kpb_pkg.
module kpb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  kpb_pkg::t_in_item i_item,
    output kpb_pkg::t_job   o_job
);

    logic [kpb_pkg::WIN_W-1:0] r_win, n_win, win0;
    logic [kpb_pkg::RUN_W-1:0] r_run, n_run, run0;
    logic                      lookup;

    // Next window and run; a monomer start clears them before the base is used.
    always_comb begin
        win0   = i_item.monomer_start ? '0 : r_win;
        run0   = i_item.monomer_start ? '0 : r_run;
        n_win  = '0;
        n_run  = '0;
        lookup = 1'b0;
        if (!kpb_pkg::is_break(i_item.base_char)) begin
            n_win  = {win0[kpb_pkg::WIN_W-3:0], kpb_pkg::base_code(i_item.base_char)};
            n_run  = (run0 < kpb_pkg::RUN_W'(kpb_pkg::KMER_LEN)) ?
                     run0 + kpb_pkg::RUN_W'(1) : run0;
            lookup = (n_run == kpb_pkg::RUN_W'(kpb_pkg::KMER_LEN));
        end
    end

    // The job goes to the queue in the cycle the word is accepted.
    always_comb begin
        o_job.code       = kpb_pkg::CODE_W'(n_win);
        o_job.lookup     = lookup;
        o_job.mono_start = i_item.monomer_start;
        o_job.mono_end   = i_item.monomer_end;
        o_job.id         = i_item.seq_id;
    end

    // Window state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_run <= '0;
        end else if (i_accept) begin
            r_win <= n_win;
            r_run <= n_run;
        end
    end

endmodule

// ----- rtl/core/kpb_jobq.sv -----
// Four-entry queue of classified jobs between the front and the back.
// Depends on kpb_pkg.
module kpb_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  kpb_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output kpb_pkg::t_job o_job
);

    localparam int DEPTH = 4;

    kpb_pkg::t_job r_slot [DEPTH];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign o_job   = r_slot[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

// ----- rtl/core/kpb_back.sv -----
// Back part: epoch-tagged presence map lookup, distinct count and results.
// Depends on kpb_pkg.
module kpb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  kpb_pkg::t_job      i_q_job,
    output logic               o_q_pop,
    input  logic               i_report,
    input  logic               i_room,
    output kpb_pkg::t_res_push o_push,
    output logic               o_sweeping
);

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } t_state;

    localparam logic [kpb_pkg::EPOCH_W-1:0] EPOCH_LAST = '1;

    kpb_pkg::t_map_row r_mem [kpb_pkg::MAP_ROWS];

    t_state                          r_state, n_state;
    logic [kpb_pkg::MAP_IDX_W-1:0]   r_sweep_row;
    logic [kpb_pkg::EPOCH_W-1:0]     r_epoch, ep_item;
    kpb_pkg::t_map_row               r_rd_data;
    logic                            r_b2_vld;
    kpb_pkg::t_job                   r_b2_job;
    logic [kpb_pkg::EPOCH_W-1:0]     r_b2_ep;
    logic                            r_fwd_vld;
    logic [kpb_pkg::MAP_IDX_W-1:0]   r_fwd_row;
    kpb_pkg::t_map_row               r_fwd_data;
    logic [kpb_pkg::CNT_W-1:0]       r_count;

    logic                            need_sweep, b2_adv, b2_free;
    logic [kpb_pkg::MAP_IDX_W-1:0]   row2;
    logic [kpb_pkg::MAP_BIT_W-1:0]   bit2;
    kpb_pkg::t_map_row               row_raw;
    logic [kpb_pkg::MAP_BITS-1:0]    bits, new_bits;
    logic                            is_new;
    logic [kpb_pkg::CNT_W-1:0]       cnt_base, cnt_new;
    logic                            wr_en;
    logic [kpb_pkg::MAP_IDX_W-1:0]   wr_row;
    kpb_pkg::t_map_row               wr_data;

    // Issue stage: a start at the last epoch waits for a clearing pass.
    assign need_sweep = !i_q_empty && i_q_job.mono_start && (r_epoch == EPOCH_LAST);
    assign b2_adv     = r_b2_vld && i_room;
    assign b2_free    = !r_b2_vld || b2_adv;
    assign o_q_pop    = (r_state == ST_RUN) && !i_q_empty && b2_free && !need_sweep;
    assign ep_item    = i_q_job.mono_start ? r_epoch + kpb_pkg::EPOCH_W'(1) : r_epoch;
    assign o_sweeping = (r_state == ST_SWEEP);

    // Test stage: forward the last write, drop rows from an older epoch.
    always_comb begin
        row2     = r_b2_job.code[kpb_pkg::CODE_W-1:kpb_pkg::MAP_BIT_W];
        bit2     = r_b2_job.code[kpb_pkg::MAP_BIT_W-1:0];
        row_raw  = (r_fwd_vld && (r_fwd_row == row2)) ? r_fwd_data : r_rd_data;
        bits     = (row_raw.tag == r_b2_ep) ? row_raw.bits : '0;
        new_bits = bits | (kpb_pkg::MAP_BITS'(1) << bit2);
        is_new   = r_b2_job.lookup && !bits[bit2];
        cnt_base = r_b2_job.mono_start ? '0 : r_count;
        cnt_new  = cnt_base + kpb_pkg::CNT_W'(is_new && (cnt_base != kpb_pkg::CNT_MAX));
    end

    // Results of the word in the test stage.
    always_comb begin
        o_push.push0                = b2_adv && is_new && i_report;
        o_push.push1                = b2_adv && r_b2_job.mono_end;
        o_push.res0.result_kind     = kpb_pkg::RK_REPORT;
        o_push.res0.kmer_code       = r_b2_job.code;
        o_push.res0.owner_id        = r_b2_job.id;
        o_push.res0.distinct_kmers  = cnt_new;
        o_push.res0.run_last        = !r_b2_job.mono_end;
        o_push.res1.result_kind     = kpb_pkg::RK_SUMMARY;
        o_push.res1.kmer_code       = '0;
        o_push.res1.owner_id        = r_b2_job.id;
        o_push.res1.distinct_kmers  = cnt_new;
        o_push.res1.run_last        = 1'b1;
    end

    // Map write port: the clearing pass or the test stage's update.
    always_comb begin
        if (r_state == ST_SWEEP) begin
            wr_en   = 1'b1;
            wr_row  = r_sweep_row;
            wr_data = '0;
        end else begin
            wr_en        = b2_adv && r_b2_job.lookup;
            wr_row       = row2;
            wr_data.tag  = r_b2_ep;
            wr_data.bits = new_bits;
        end
    end

    // Next control state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_SWEEP: begin
                if (r_sweep_row == '1) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (need_sweep && !r_b2_vld) begin
                    n_state = ST_SWEEP;
                end
            end
            default: n_state = ST_SWEEP;
        endcase
    end

    // Control state, epoch, test stage and forwarding registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep_row <= '0;
            r_epoch     <= '0;
            r_b2_vld    <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP) begin
                r_sweep_row <= r_sweep_row + kpb_pkg::MAP_IDX_W'(1);
                r_epoch     <= '0;
                r_fwd_vld   <= 1'b0;
            end else if (wr_en) begin
                r_fwd_vld <= 1'b1;
            end
            if (o_q_pop) begin
                r_epoch <= ep_item;
            end
            if (b2_adv) begin
                r_count <= cnt_new;
            end
            if (o_q_pop) begin
                r_b2_vld <= 1'b1;
            end else if (b2_adv) begin
                r_b2_vld <= 1'b0;
            end
        end
    end

    // Payload of the test stage and of the forwarding path.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b2_job <= i_q_job;
            r_b2_ep  <= ep_item;
        end
        if (wr_en && (r_state == ST_RUN)) begin
            r_fwd_row  <= wr_row;
            r_fwd_data <= wr_data;
        end
    end

    // Presence map memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_row] <= wr_data;
        end
        if (o_q_pop) begin
            r_rd_data <= r_mem[i_q_job.code[kpb_pkg::CODE_W-1:kpb_pkg::MAP_BIT_W]];
        end
    end

    // A clearing pass never overlaps a lookup.
    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !o_q_pop)
        else $error("job issued during map clearing pass");

    // A pass starts only once the test stage has drained.
    a_sweep_entry_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && (n_state == ST_SWEEP)) |-> !r_b2_vld)
        else $error("clearing pass started with a lookup in flight");

    // The distinct count never passes the size of the code space.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= kpb_pkg::CNT_MAX)
        else $error("distinct count out of range");

endmodule

// ----- rtl/core/kpb_resq.sv -----
// Four-entry result queue that takes up to two results per cycle.
// Depends on kpb_pkg.
module kpb_resq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kpb_pkg::t_res_push i_push,
    output logic               o_room,
    input  logic               i_pop,
    output logic               o_empty,
    output kpb_pkg::t_out_item o_item
);

    localparam int DEPTH = 4;

    kpb_pkg::t_out_item r_slot [DEPTH];
    logic [1:0]         r_wp, r_rp, wp1;
    logic [2:0]         r_cnt, n_cnt;
    logic [1:0]         n_push;

    assign o_room  = (r_cnt <= 3'(DEPTH - 2));
    assign o_empty = (r_cnt == 3'd0);
    assign o_item  = r_slot[r_rp];
    assign n_push  = 2'(i_push.push0) + 2'(i_push.push1);
    assign wp1     = i_push.push0 ? r_wp + 2'd1 : r_wp;
    assign n_cnt   = r_cnt + 3'(n_push) - 3'(i_pop);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + n_push;
            r_cnt <= n_cnt;
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
        end
    end

    // The report goes in first, the summary behind it.
    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_slot[r_wp] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_slot[wp1] <= i_push.res1;
        end
    end

    // Two results are pushed only when two slots are free.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.push0 || i_push.push1) |-> o_room)
        else $error("result pushed without room");

    // The fill count tracks pushes and pops.
    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_cnt == $past(n_cnt)) && (r_cnt <= 3'(DEPTH)))
        else $error("result queue count out of step");

endmodule

// ----- rtl/core/kmer_presence_bitvector_unit.sv -----
// Top level of the k-mer presence unit: APB register, front, job queue, back, result queue.
// Depends on kpb_pkg, kpb_front, kpb_jobq, kpb_back and kpb_resq.
//
// The unit takes one base per cycle and keeps up that rate: a word is
// accepted every clock as long as results are taken and no clearing pass
// runs, and each word leaves 0, 1 or 2 result words (a first-seen k-mer report,
// a monomer summary) that pass via the job queue and test stage to the result
// queue. The rate is set by the read, test and write of the 1024 x 64-bit
// presence map (plus its tag), which does one row read and one row write per
// cycle and is kept whole with a bypass of the last written row. The map is
// cleared per monomer by a 12-bit epoch tag; after reset, and again when the
// tag runs out (the 4096th monomer start after reset and every 4095th start
// after that), a pass clears all 1024 map rows while full stays high.
module kmer_presence_bitvector_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  kpb_pkg::t_in_item  i_data,
    output logic               empty,
    input  logic               pop,
    output kpb_pkg::t_out_item o_data
);

    logic               r_report;
    logic               accept, q_full, q_empty, q_pop, room, sweeping, res_empty;
    kpb_pkg::t_job      front_job, q_job;
    kpb_pkg::t_res_push res_push;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == kpb_pkg::REG_REPORT) ? {31'd0, r_report} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report <= 1'b1;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == kpb_pkg::REG_REPORT)) begin
            r_report <= pwdata[0];
        end
    end

    // Input handshake.
    assign full   = q_full || sweeping;
    assign accept = push && !full;
    assign empty  = res_empty;

    kpb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .o_job    (front_job)
    );

    kpb_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    kpb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_job    (q_job),
        .o_q_pop    (q_pop),
        .i_report   (r_report),
        .i_room     (room),
        .o_push     (res_push),
        .o_sweeping (sweeping)
    );

    kpb_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_room  (room),
        .i_pop   (pop && !res_empty),
        .o_empty (res_empty),
        .o_item  (o_data)
    );

endmodule

// ----- test/kmer_result_checker.sv -----
// Scoreboard for the k-mer presence unit: predicts result words and compares them.
// Depends on kpb_pkg; instantiated beside the block by kmer_presence_bitvector_unit_tb.
module kmer_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    input  logic               push,
    input  logic               full,
    input  kpb_pkg::t_in_item  i_data,
    input  logic               empty,
    input  logic               pop,
    input  kpb_pkg::t_out_item o_data,
    output int                 o_pending,
    output int                 o_fail_count,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import kpb_pkg::*;

    // Result words still owed by the block, oldest first.
    t_out_item due_results[$];

    // Presence map kept as the monomer epoch in which each code was last seen.
    int unsigned seen_epoch [0:(1 << CODE_W) - 1];
    int unsigned map_epoch = 1;

    logic [WIN_W-1:0] win_bits     = '0;
    int               clean_len    = 0;
    logic [CNT_W-1:0] distinct_cnt = '0;
    logic             report_on    = 1'b1;
    int               fails        = 0;
    int               checked      = 0;

    // Letters are folded to lower case; anything unrecognized counts as A.
    function automatic logic [1:0] char_to_base(input logic [CHAR_W-1:0] ch);
        case (ch | 8'h20)
            CH_C_LO: return BASE_C;
            CH_G_LO: return BASE_G;
            CH_T_LO: return BASE_T;
            default: return BASE_A;
        endcase
    endfunction

    function automatic bit field_bad(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (want === got) return 1'b0;
        $display("%0t: result word %0d, %s expected 0x%0h, actual 0x%0h",
                 $time, checked, name, want, got);
        return 1'b1;
    endfunction

    // Works out the result words that one accepted input word causes.
    task automatic predict_word(input t_in_item w);
        t_out_item r;
        if (w.monomer_start) begin
            win_bits     = '0;
            clean_len    = 0;
            distinct_cnt = '0;
            map_epoch++;
        end
        if ((w.base_char | 8'h20) == CH_N_LO) begin
            win_bits  = '0;
            clean_len = 0;
        end else begin
            win_bits = {win_bits[WIN_W-3:0], char_to_base(w.base_char)};
            if (clean_len < KMER_LEN) clean_len++;
            // A full window tests and sets its code in this monomer's map.
            if (clean_len >= KMER_LEN && seen_epoch[win_bits] != map_epoch) begin
                seen_epoch[win_bits] = map_epoch;
                if (distinct_cnt < CNT_MAX) distinct_cnt++;
                if (report_on) begin
                    r.result_kind    = RK_REPORT;
                    r.kmer_code      = win_bits;
                    r.owner_id       = w.seq_id;
                    r.distinct_kmers = distinct_cnt;
                    r.run_last       = !w.monomer_end;
                    due_results.push_back(r);
                end
            end
        end
        if (w.monomer_end) begin
            r.result_kind    = RK_SUMMARY;
            r.kmer_code      = '0;
            r.owner_id       = w.seq_id;
            r.distinct_kmers = distinct_cnt;
            r.run_last       = 1'b1;
            due_results.push_back(r);
        end
    endtask

    // Register traffic, result words and input words, all sampled at the rising edge.
    always @(posedge i_clk) begin : watch
        t_out_item want;
        bit        bad;
        if (!i_rst_n) begin
            win_bits     = '0;
            clean_len    = 0;
            distinct_cnt = '0;
            report_on    = 1'b1;
            map_epoch++;
            due_results.delete();
        end else begin
            if (psel && penable && pready && paddr[1:0] == 2'b00
                    && paddr[2:2] == REG_REPORT) begin
                if (pwrite) begin
                    report_on = pwdata[0];
                end else if (prdata !== {31'b0, report_on}) begin
                    fails++;
                    $display("%0t: register read expected 0x%0h, actual 0x%0h",
                             $time, {31'b0, report_on}, prdata);
                end
            end
            if (pop && !empty) begin
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: result word with none expected, actual 0x%0h",
                             $time, o_data);
                end else begin
                    want = due_results.pop_front();
                    bad  = field_bad("result_kind", 32'(want.result_kind),
                                     32'(o_data.result_kind))
                         | field_bad("kmer_code", 32'(want.kmer_code),
                                     32'(o_data.kmer_code))
                         | field_bad("owner_id", 32'(want.owner_id),
                                     32'(o_data.owner_id))
                         | field_bad("distinct_kmers", 32'(want.distinct_kmers),
                                     32'(o_data.distinct_kmers))
                         | field_bad("run_last", 32'(want.run_last),
                                     32'(o_data.run_last));
                    if (bad) fails++;
                    checked++;
                end
            end
            if (push && !full) predict_word(i_data);
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ----- test/kmer_presence_bitvector_unit_tb.sv -----
// Stimulus and verdict for the k-mer presence unit: monomer streams, register writes, stalls.
// Depends on kpb_pkg, kmer_presence_bitvector_unit and kmer_result_checker.
module kmer_presence_bitvector_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kpb_pkg::*;

    localparam int   CYCLE_LIMIT   = 400_000;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   PHASE_WORDS   = 640;
    localparam logic REG_UNUSED    = 1'b1;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push    = 1'b0;
    logic        full;
    t_in_item    in_word = '0;
    logic        empty;
    logic        pop     = 1'b0;
    t_out_item   out_word;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent    = 0;
    int starts_sent   = 0;
    int pending;
    int fail_count;
    int results_seen;

    kmer_presence_bitvector_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .i_data  (in_word),
        .empty   (empty),
        .pop     (pop),
        .o_data  (out_word)
    );

    kmer_result_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .i_data       (in_word),
        .empty        (empty),
        .pop          (pop),
        .o_data       (out_word),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (results_seen)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // The result side stalls at random according to the current idle rate.
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("kmer_presence_bitvector_unit_tb: FAIL");
        $finish;
    end

    // Offers one word, with random gaps ahead of it, and returns once it is taken.
    task automatic send_word(input t_in_item w);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_word <= w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
        if (w.monomer_start) starts_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic st, input logic en,
                             input logic [ID_W-1:0] id);
        t_in_item w;
        w.base_char     = ch;
        w.monomer_start = st;
        w.monomer_end   = en;
        w.seq_id        = id;
        send_word(w);
    endtask

    // Sends a string as bases, marking its first and last character as asked.
    task automatic send_text(input string s, input logic [ID_W-1:0] id, input logic st,
                             input logic en);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], st && i == 0, en && i == s.len() - 1, id);
    endtask

    function automatic logic [CHAR_W-1:0] clean_base();
        logic [CHAR_W-1:0] ch;
        case ($urandom_range(3))
            0:       ch = "A";
            1:       ch = CH_C_UP;
            2:       ch = CH_G_UP;
            default: ch = CH_T_UP;
        endcase
        if ($urandom_range(1)) ch = ch | 8'h20;
        return ch;
    endfunction

    // Mostly real bases, with the odd break and the odd arbitrary byte.
    function automatic logic [CHAR_W-1:0] noisy_base();
        int r;
        r = $urandom_range(99);
        if (r < 4) return $urandom_range(1) ? CH_N_UP : CH_N_LO;
        if (r < 7) return CHAR_W'($urandom_range(255));
        return clean_base();
    endfunction

    // A monomer of random bases, or of a short repeated motif so k-mers recur.
    task automatic send_monomer(input int len, input logic st, input logic en,
                                input bit motif);
        logic [ID_W-1:0]   id;
        logic [CHAR_W-1:0] pattern [6];
        int                plen;
        logic [CHAR_W-1:0] ch;
        id   = ID_W'($urandom_range(20'hFFFFF));
        plen = $urandom_range(1, 6);
        for (int i = 0; i < 6; i++) pattern[i] = clean_base();
        for (int i = 0; i < len; i++) begin
            ch = motif ? pattern[i % plen] : noisy_base();
            send_char(ch, st && i == 0, en && i == len - 1, id);
        end
    endtask

    // Arbitrary bytes with stray marks and ids.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            send_char(CHAR_W'($urandom_range(255)), $urandom_range(9) == 0,
                      $urandom_range(9) == 0, ID_W'($urandom_range(20'hFFFFF)));
    endtask

    // Random traffic, mostly well-formed monomers; optionally one full drain midway.
    task automatic run_random(input int count, input bit with_pause);
        int  goal;
        int  r;
        bit  paused;
        goal   = words_sent + count;
        paused = 1'b0;
        while (words_sent < goal) begin
            if (with_pause && !paused && words_sent >= goal - count / 2) begin
                push <= 1'b0;
                while (pending != 0) @(negedge i_clk);
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 55)
                send_monomer($urandom_range(1, 24), 1'b1, 1'b1, 1'b0);
            else if (r < 72)
                send_monomer($urandom_range(8, 30), 1'b1, 1'b1, 1'b1);
            else if (r < 77)
                send_monomer($urandom_range(40, 120), 1'b1, 1'b1, r[0]);
            else if (r < 86)
                send_noise();
            else if (r < 95)
                send_monomer($urandom_range(1, 20), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                send_char(clean_base(), 1'b1, 1'b1, ID_W'($urandom_range(20'hFFFFF)));
        end
    endtask

    // Waits until every owed word has come, plus room for words that cause none.
    task automatic drain_and_idle();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register access: setup cycle, access cycle, then a quiet cycle.
    task automatic reg_access(input logic wr, input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reporting on; a write to an address with no register must change nothing.
        reg_access(1'b1, REG_REPORT, 32'h0000_0001);
        reg_access(1'b1, REG_UNUSED, 32'hFFFF_FFFF);
        reg_access(1'b0, REG_REPORT, 32'h0);

        send_idle_pct = 12;
        recv_idle_pct = 46;

        // Start and end on one base: summary with a zero count.
        send_char("A", 1'b1, 1'b1, 20'h00000);
        // Short monomer with a break inside: only its summary.
        send_text("AcNgT", 20'hFFFFF, 1'b1, 1'b1);
        // A break, then a run of T: the all-ones code once, then repeats stay quiet.
        send_text("TTNTTTTTTTTT", 20'h5A5A5, 1'b1, 1'b1);
        // A base with no marks carries on the window after the end mark.
        send_char("g", 1'b0, 1'b0, 20'hA5A5A);
        // Zero and 0xFF bytes count as A; the first k-mer lands on the end base.
        send_char(8'h00, 1'b1, 1'b0, 20'h3C3C3);
        send_char(8'hFF, 1'b0, 1'b0, 20'h3C3C3);
        send_text("cGtagC", 20'h3C3C3, 1'b0, 1'b1);

        run_random(PHASE_WORDS, 1'b0);
        drain_and_idle();

        // Reporting off: only summaries come out; upper data bits are ignored.
        reg_access(1'b1, REG_REPORT, 32'hFFFF_FFFE);
        reg_access(1'b0, REG_REPORT, 32'h0);
        send_idle_pct = 46;
        recv_idle_pct = 12;
        run_random(PHASE_WORDS, 1'b0);
        drain_and_idle();

        // Reporting back on, both sides at full rate.
        reg_access(1'b1, REG_REPORT, 32'h8000_0001);
        reg_access(1'b0, REG_REPORT, 32'h0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_WORDS, 1'b1);
        drain_and_idle();

        $display("Sent %0d input words over %0d monomer starts; checked %0d result words",
                 words_sent, starts_sent, results_seen);
        $display("with reporting on, off and on again under three stall profiles.");
        if (fail_count == 0)
            $display("kmer_presence_bitvector_unit_tb: PASS");
        else
            $display("kmer_presence_bitvector_unit_tb: FAIL");
        $finish;
    end

endmodule
